// ===== hdl/plfr_pkg.sv =====
// Shared constants and types for the phone link frame receiver.
package plfr_pkg;

  localparam logic [7:0] FRAME_ID  = 8'h1E;
  localparam logic [7:0] DEST_ADDR = 8'h0C;
  localparam logic [7:0] SRC_ADDR  = 8'h00;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_DONE    = 2'd1;
  localparam logic [1:0] KIND_HDR_ERR = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_ID   = 3'd1;
  localparam logic [2:0] ST_BAD_DEST = 3'd2;
  localparam logic [2:0] ST_BAD_SRC  = 3'd3;
  localparam logic [2:0] ST_ZERO_LEN = 3'd4;
  localparam logic [2:0] ST_EVEN_XOR = 3'd5;
  localparam logic [2:0] ST_ODD_XOR  = 3'd6;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [2:0]  status;
    logic [7:0]  command;
    logic [7:0]  sequence_res;
    logic [15:0] payload_length;
    logic        last;
  } res_t;

endpackage

// ===== hdl/plfr_parser.sv =====
// Frame parser: phase state machine, checksums and result formation.
module plfr_parser
  import plfr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       adv_i,
  input  logic [7:0] byte_i,
  output logic       res_valid_o,
  output res_t       res_o
);

  localparam logic [3:0] PH_HUNT = 4'd0;
  localparam logic [3:0] PH_DEST = 4'd1;
  localparam logic [3:0] PH_SRC  = 4'd2;
  localparam logic [3:0] PH_CMD  = 4'd3;
  localparam logic [3:0] PH_LENH = 4'd4;
  localparam logic [3:0] PH_LENL = 4'd5;
  localparam logic [3:0] PH_DATA = 4'd6;
  localparam logic [3:0] PH_SEQ  = 4'd7;
  localparam logic [3:0] PH_PAD  = 4'd8;
  localparam logic [3:0] PH_EVEN = 4'd9;
  localparam logic [3:0] PH_ODD  = 4'd10;

  logic [3:0]  phase_q, phase_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [15:0] len_q, len_d;
  logic [15:0] cnt_q, cnt_d;
  logic [7:0]  seq_q, seq_d;
  logic [7:0]  even_q, even_d;
  logic [7:0]  odd_q, odd_d;
  logic        even_ok_q, even_ok_d;
  logic [15:0] plen;
  logic [15:0] cnt_inc;
  logic [15:0] len_full;

  assign plen     = len_q - 16'd1;
  assign cnt_inc  = cnt_q + 16'd1;
  assign len_full = {len_q[15:8], byte_i};

  always_comb begin
    phase_d     = phase_q;
    cmd_d       = cmd_q;
    len_d       = len_q;
    cnt_d       = cnt_q;
    seq_d       = seq_q;
    even_d      = even_q;
    odd_d       = odd_q;
    even_ok_d   = even_ok_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.last  = 1'b1;
    case (phase_q)
      PH_DEST: begin
        if (byte_i != DEST_ADDR) begin
          phase_d      = PH_HUNT;
          res_valid_o  = 1'b1;
          res_o.kind   = KIND_HDR_ERR;
          res_o.status = ST_BAD_DEST;
        end else begin
          odd_d   = odd_q ^ byte_i;
          phase_d = PH_SRC;
        end
      end
      PH_SRC: begin
        if (byte_i != SRC_ADDR) begin
          phase_d      = PH_HUNT;
          res_valid_o  = 1'b1;
          res_o.kind   = KIND_HDR_ERR;
          res_o.status = ST_BAD_SRC;
        end else begin
          even_d  = even_q ^ byte_i;
          phase_d = PH_CMD;
        end
      end
      PH_CMD: begin
        cmd_d   = byte_i;
        odd_d   = odd_q ^ byte_i;
        phase_d = PH_LENH;
      end
      PH_LENH: begin
        len_d   = {byte_i, 8'h00};
        even_d  = even_q ^ byte_i;
        phase_d = PH_LENL;
      end
      PH_LENL: begin
        len_d = len_full;
        odd_d = odd_q ^ byte_i;
        if (len_full == 16'd0) begin
          phase_d       = PH_HUNT;
          res_valid_o   = 1'b1;
          res_o.kind    = KIND_HDR_ERR;
          res_o.status  = ST_ZERO_LEN;
          res_o.command = cmd_q;
        end else begin
          cnt_d   = 16'd0;
          phase_d = (len_full == 16'd1) ? PH_SEQ : PH_DATA;
        end
      end
      PH_DATA: begin
        if (!cnt_q[0]) even_d = even_q ^ byte_i;
        else           odd_d  = odd_q ^ byte_i;
        cnt_d = cnt_inc;
        if (cnt_inc >= plen) phase_d = PH_SEQ;
        res_valid_o          = 1'b1;
        res_o.kind           = KIND_PAYLOAD;
        res_o.payload_byte   = byte_i;
        res_o.command        = cmd_q;
        res_o.payload_length = plen;
        res_o.last           = 1'b0;
      end
      PH_SEQ: begin
        seq_d = byte_i;
        if (!plen[0]) begin
          even_d  = even_q ^ byte_i;
          phase_d = PH_PAD;
        end else begin
          odd_d   = odd_q ^ byte_i;
          phase_d = PH_EVEN;
        end
      end
      PH_PAD: begin
        odd_d   = odd_q ^ byte_i;
        phase_d = PH_EVEN;
      end
      PH_EVEN: begin
        even_ok_d = (byte_i == even_q);
        phase_d   = PH_ODD;
      end
      PH_ODD: begin
        phase_d              = PH_HUNT;
        res_valid_o          = 1'b1;
        res_o.kind           = KIND_DONE;
        res_o.status         = !even_ok_q ? ST_EVEN_XOR :
                               ((byte_i != odd_q) ? ST_ODD_XOR : ST_OK);
        res_o.command        = cmd_q;
        res_o.sequence_res   = seq_q;
        res_o.payload_length = plen;
      end
      default: begin
        phase_d = PH_HUNT;
        if (byte_i != FRAME_ID) begin
          res_valid_o  = 1'b1;
          res_o.kind   = KIND_HDR_ERR;
          res_o.status = ST_BAD_ID;
        end else begin
          even_d    = byte_i;
          odd_d     = 8'h00;
          even_ok_d = 1'b0;
          phase_d   = PH_DEST;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HUNT;
      cmd_q     <= '0;
      len_q     <= '0;
      cnt_q     <= '0;
      seq_q     <= '0;
      even_q    <= '0;
      odd_q     <= '0;
      even_ok_q <= 1'b0;
    end else if (adv_i) begin
      phase_q   <= phase_d;
      cmd_q     <= cmd_d;
      len_q     <= len_d;
      cnt_q     <= cnt_d;
      seq_q     <= seq_d;
      even_q    <= even_d;
      odd_q     <= odd_d;
      even_ok_q <= even_ok_d;
    end
  end

endmodule

// ===== hdl/plfr_out_reg.sv =====
// Output register holding one result request until the sink takes it.
module plfr_out_reg
  import plfr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic adv_i,
  input  logic res_valid_i,
  input  res_t res_i,
  output logic free_o,
  input  logic stall_i,
  output logic valid_o,
  output res_t res_o
);

  logic valid_q;
  res_t res_q;

  assign free_o  = !valid_q || !stall_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= adv_i && res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && adv_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

endmodule

// ===== hdl/phone_link_frame_receiver.sv =====
// Top level: input register, frame parser and output register.
// An accepted byte is held in the input register; its result is held in the output register.
// Throughput: one byte per cycle unless the sink stalls; both registers run concurrently.
// Valid header, sequence, pad and even checksum bytes give no result; bad header bytes do.
// Reset (rst_ni low, asynchronous) empties both registers and returns the parser to hunting.
module phone_link_frame_receiver
  import plfr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [2:0]  status_o,
  output logic [7:0]  command_o,
  output logic [7:0]  sequence_res_o,
  output logic [15:0] payload_length_o,
  output logic        last_o
);

  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       free;
  logic       adv;
  logic       accept;
  logic       res_valid;
  res_t       res;
  res_t       out_res;

  assign adv        = in_valid_q && free;
  assign in_stall_o = in_valid_q && !free;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= rx_byte_i;
    end
  end

  plfr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .byte_i      (byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  plfr_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .res_valid_i (res_valid),
    .res_i       (res),
    .free_o      (free),
    .stall_i     (out_stall_i),
    .valid_o     (out_valid_o),
    .res_o       (out_res)
  );

  assign kind_o           = out_res.kind;
  assign payload_byte_o   = out_res.payload_byte;
  assign status_o         = out_res.status;
  assign command_o        = out_res.command;
  assign sequence_res_o   = out_res.sequence_res;
  assign payload_length_o = out_res.payload_length;
  assign last_o           = out_res.last;

endmodule

// ===== hdl/plfr_checker.sv =====
// Port-level checks for the phone link frame receiver, bound to the top level.
module plfr_checker
  import plfr_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  kind_o,
  input logic [2:0]  status_o,
  input logic [7:0]  sequence_res_o,
  input logic [15:0] payload_length_o,
  input logic        last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) && $stable(status_o))
    else $error("stalled result request changed");

  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (kind_o != KIND_PAYLOAD)))
    else $error("last flag does not match result kind");

  a_payload_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_PAYLOAD |-> status_o == ST_OK && sequence_res_o == 8'd0)
    else $error("payload request carries status or sequence");

  a_hdr_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_HDR_ERR |->
      payload_length_o == 16'd0 && status_o != ST_OK && status_o != ST_EVEN_XOR
      && status_o != ST_ODD_XOR)
    else $error("header error request malformed");

endmodule

bind phone_link_frame_receiver plfr_checker u_plfr_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .kind_o           (kind_o),
  .status_o         (status_o),
  .sequence_res_o   (sequence_res_o),
  .payload_length_o (payload_length_o),
  .last_o           (last_o)
);
